FILE: rtl/dbir_pkg.sv
// Shared constants and types for the depth bin index range table.
package dbir_pkg;

  localparam int NUM_BINS_DEF = 1024;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 16;
  localparam int DEPTH_W = 24;
  localparam int MAG_W   = 23;
  localparam int ADDR_W  = 10;
  localparam int BIN_W   = 32;
  localparam int CNT_W   = 5;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [BIN_W-1:0] EMPTY_BIN       = 32'hFFFF_0000;
  localparam logic [MAG_W-1:0] BIN_DEPTH_RESET = 23'd256;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/dbir_ram.sv
// Generic simple dual-port RAM with registered read.
module dbir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/dbir_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module dbir_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dbir_pkg::div_req_t req,
  output dbir_pkg::div_rsp_t rsp
);

  localparam int MW = dbir_pkg::MAG_W;

  logic [MW-1:0]              rem_r, rem_nxt;
  logic [MW-1:0]              quo_r, quo_nxt;
  logic [MW-1:0]              dvs_r, dvs_nxt;
  logic [dbir_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [MW:0]                shifted;
  logic [MW+1:0]              diff;

  always_comb begin
    shifted  = {rem_r, quo_r[MW-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = dbir_pkg::CNT_W'(MW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[MW+1]) begin
        rem_nxt = diff[MW-1:0];
        quo_nxt = {quo_r[MW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[MW-1:0];
        quo_nxt = {quo_r[MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dbir_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("divider restarted mid-division");

  a_busy_drops_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r)
    else $error("divider stopped without done");

endmodule

FILE: rtl/depth_bin_index_range.sv
// Top level of the depth bin index range table: sequencer, bin RAM and divider.
//
// Input transactions use in_valid/in_ready; results use out_valid/out_ready.
// Each input transaction gives one result.
//   clear : sweeps every bin to empty, one bin per cycle, result fields zero.
//   insert: near and far depths go one after the other through one shared
//           23-step divider, then each bin in the span is read (ST_RD) and
//           written back (ST_WR) in turn. An inverted span changes nothing.
//           Result fields zero.
//   read  : goes through the registered RAM port; an address at or above
//           NUM_BINS returns zero.
//   unused opcode: zero result.
// in_ready is high only while no transaction is being worked on. A finished
// result sits in the output register; the next transaction is accepted while
// it waits, and its own result holds in the sequencer until out_ready frees
// the register.
// Reset (rst_n low, synchronous) sets bin_depth to 256 and starts a clearing
// pass over every bin; in_ready stays low until it ends. cfg_wr_en writes
// bin_depth at once; a bin_depth of zero divides as one.
module depth_bin_index_range #(
  parameter int NUM_BINS = dbir_pkg::NUM_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dbir_pkg::OP_W-1:0]           in_opcode,
  input  logic [dbir_pkg::IDX_W-1:0]          in_object_index,
  input  logic signed [dbir_pkg::DEPTH_W-1:0] in_near_depth,
  input  logic signed [dbir_pkg::DEPTH_W-1:0] in_far_depth,
  input  logic [dbir_pkg::ADDR_W-1:0]         in_bin_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dbir_pkg::IDX_W-1:0]          out_bin_min_index,
  output logic [dbir_pkg::IDX_W-1:0]          out_bin_max_index,
  input  logic                                cfg_wr_en,
  input  logic [dbir_pkg::MAG_W-1:0]          cfg_wr_data
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int MW = dbir_pkg::MAG_W;
  localparam int IW = dbir_pkg::IDX_W;
  localparam logic [MW-1:0] LAST_BIN = MW'(NUM_BINS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

  localparam logic [2:0] ST_CLR      = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DIV_NEAR = 3'd2;
  localparam logic [2:0] ST_DIV_FAR  = 3'd3;
  localparam logic [2:0] ST_RD       = 3'd4;
  localparam logic [2:0] ST_WR       = 3'd5;
  localparam logic [2:0] ST_RDOUT    = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [MW-1:0] far_mag_r, far_mag_nxt;
  logic [IW-1:0] res_min_r, res_min_nxt;
  logic [IW-1:0] res_max_r, res_max_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_min_r, out_min_nxt;
  logic [IW-1:0] out_max_r, out_max_nxt;
  logic [MW-1:0] bin_depth_r;

  dbir_pkg::div_req_t div_req;
  dbir_pkg::div_rsp_t div_rsp;

  logic                       accept;
  logic                       addr_ok;
  logic [MW-1:0]              near_mag;
  logic [MW-1:0]              q_clamped;
  logic [AW-1:0]              q_bin;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [dbir_pkg::BIN_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [dbir_pkg::BIN_W-1:0] ram_rdata;
  logic [IW-1:0]              cur_min;
  logic [IW-1:0]              cur_max;
  logic [IW-1:0]              new_min;
  logic [IW-1:0]              new_max;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign addr_ok  = 32'(in_bin_address) < 32'(NUM_BINS);
  assign near_mag = in_near_depth[dbir_pkg::DEPTH_W-1] ? '0 : in_near_depth[MW-1:0];

  assign q_clamped = (div_rsp.quotient > LAST_BIN) ? LAST_BIN : div_rsp.quotient;
  assign q_bin     = AW'(q_clamped);

  assign cur_min = ram_rdata[dbir_pkg::BIN_W-1:IW];
  assign cur_max = ram_rdata[IW-1:0];
  assign new_min = (idx_r < cur_min) ? idx_r : cur_min;
  assign new_max = (idx_r > cur_max) ? idx_r : cur_max;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = (state_r == ST_IDLE) ? near_mag : far_mag_r;
    div_req.divisor  = (bin_depth_r == '0) ? MW'(1) : bin_depth_r;

    ram_we    = 1'b0;
    ram_waddr = j_r;
    ram_wdata = {new_min, new_max};
    ram_re    = 1'b0;
    ram_raddr = (state_r == ST_IDLE) ? AW'(in_bin_address) : j_r;

    state_nxt     = state_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    far_mag_nxt   = far_mag_r;
    res_min_nxt   = res_min_r;
    res_max_nxt   = res_max_r;
    out_valid_nxt = out_valid_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = dbir_pkg::EMPTY_BIN;
        j_nxt     = j_r + 1'b1;
        if (j_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
          if (lo_r[0]) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_min_nxt = '0;
          res_max_nxt = '0;
          idx_nxt     = in_object_index;
          far_mag_nxt = in_far_depth[dbir_pkg::DEPTH_W-1] ? '0 : in_far_depth[MW-1:0];
          case (in_opcode)
            dbir_pkg::OP_CLEAR: begin
              j_nxt     = '0;
              lo_nxt    = AW'(1);
              state_nxt = ST_CLR;
            end
            dbir_pkg::OP_INSERT: begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV_NEAR;
            end
            dbir_pkg::OP_READ: begin
              if (addr_ok) begin
                ram_re    = 1'b1;
                state_nxt = ST_RDOUT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV_NEAR: begin
        if (div_rsp.done) begin
          lo_nxt        = q_bin;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_FAR;
        end
      end
      ST_DIV_FAR: begin
        if (div_rsp.done) begin
          hi_nxt = q_bin;
          j_nxt  = lo_r;
          if (lo_r > q_bin) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        ram_we = 1'b1;
        j_nxt  = j_r + 1'b1;
        if (j_r == hi_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RDOUT: begin
        res_min_nxt = cur_min;
        res_max_nxt = cur_max;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = res_min_r;
          out_max_nxt   = res_max_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      j_r         <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
      bin_depth_r <= dbir_pkg::BIN_DEPTH_RESET;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        bin_depth_r <= cfg_wr_data;
      end
    end
    hi_r      <= hi_nxt;
    idx_r     <= idx_nxt;
    far_mag_r <= far_mag_nxt;
    res_min_r <= res_min_nxt;
    res_max_r <= res_max_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
  end

  dbir_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  dbir_ram #(
    .WIDTH(dbir_pkg::BIN_W),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_bin_min_index = out_min_r;
  assign out_bin_max_index = out_max_r;

  a_span_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> (j_r >= lo_r && j_r <= hi_r))
    else $error("bin update outside the insert span");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_NEAR || state_r == ST_DIV_FAR))
    else $error("divider result with no insert waiting");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !ram_we)
    else $error("bin RAM written with no transaction in progress");

endmodule
